// ===== hdl/sfd_pkg.sv =====
// Package for the serial frame deframer: widths, marker and code constants,
// the register and result structures. No dependencies.
package sfd_pkg;

  // Largest payload length a frame may declare
  localparam int unsigned MAX_PAYLOAD_LEN = 64;

  // Widths derived from the payload limit
  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD_LEN + 1);
  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD_LEN + 9);

  // Configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_LOWEST_TYPE  = 2'd0;
  localparam logic [1:0] REG_HIGHEST_TYPE = 2'd1;
  localparam logic [1:0] REG_EXP_ACK_CNT  = 2'd2;

  // Marker byte range; the start marker is FB FC FD FE in order
  localparam logic [7:0] MARKER_FIRST = 8'hFB;
  localparam logic [7:0] MARKER_LAST  = 8'hFE;

  // Result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  // Drop reasons
  localparam logic [2:0] DROP_MARKER   = 3'd0;
  localparam logic [2:0] DROP_TYPE     = 3'd1;
  localparam logic [2:0] DROP_ACK_CNT  = 3'd2;
  localparam logic [2:0] DROP_LENGTH   = 3'd3;
  localparam logic [2:0] DROP_CHECKSUM = 3'd4;

  typedef struct packed {
    logic [7:0] lowest_type;
    logic [7:0] highest_type;
    logic [7:0] expected_ack_counter;
  } sfd_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] frame_type;
    logic [7:0] frame_counter;
    logic       is_ack;
    logic [6:0] decoded_length;
    logic [2:0] drop_reason;
  } sfd_result_t;

endpackage

// ===== hdl/sfd_if.sv =====
// Channel interfaces for the deframer: received byte stream and result stream.
// Depends on sfd_pkg.
interface sfd_byte_if import sfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_result_if import sfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [7:0] frame_type;
  logic [7:0] frame_counter;
  logic       is_ack;
  logic [6:0] decoded_length;
  logic [2:0] drop_reason;

  modport source (output valid, output kind, output data_byte, output frame_type,
                  output frame_counter, output is_ack, output decoded_length,
                  output drop_reason, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_type,
                input frame_counter, input is_ack, input decoded_length,
                input drop_reason, output ready);
endinterface

// ===== hdl/sfd_regs.sv =====
// APB-style configuration registers of the deframer (type range, ack counter).
// Depends on sfd_pkg.
module sfd_regs import sfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output sfd_cfg_t          cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes in the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lowest_type          <= 8'd0;
      cfg.highest_type         <= 8'hFF;
      cfg.expected_ack_counter <= 8'd0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_LOWEST_TYPE:  cfg.lowest_type          <= pwdata[7:0];
        REG_HIGHEST_TYPE: cfg.highest_type         <= pwdata[7:0];
        REG_EXP_ACK_CNT:  cfg.expected_ack_counter <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_LOWEST_TYPE:  prdata[7:0] = cfg.lowest_type;
      REG_HIGHEST_TYPE: prdata[7:0] = cfg.highest_type;
      REG_EXP_ACK_CNT:  prdata[7:0] = cfg.expected_ack_counter;
      default:          prdata      = '0;
    endcase
  end

endmodule

// ===== hdl/sfd_core.sv =====
// Deframer core: input byte register, frame parse state and one-pass decode
// of each byte into at most one result. Depends on sfd_pkg.
module sfd_core import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sfd_cfg_t    cfg,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  output logic        in_ready,
  input  logic        res_full,
  output logic        res_push,
  output sfd_result_t res_data
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;

  // Frame state
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [LEN_W-1:0] declared_length, declared_length_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       sum_high_byte, sum_high_byte_next;
  logic [7:0]       held_type, held_type_next;
  logic [7:0]       held_counter, held_counter_next;
  logic             skip_pending, skip_pending_next;
  logic [LEN_W-1:0] kept_count, kept_count_next;

  logic             restart;
  logic             has_result;
  sfd_result_t      result;
  logic [POS_W-1:0] pay_end;
  logic [15:0]      sum_plus;
  logic             is_marker;

  assign advance  = s1_valid && !res_full;
  assign in_ready = !s1_valid || !res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
    end
  end

  assign pay_end   = POS_W'(7) + POS_W'(declared_length);
  assign sum_plus  = running_sum + {8'd0, s1_byte};
  assign is_marker = (s1_byte >= MARKER_FIRST) && (s1_byte <= MARKER_LAST);

  // Decode of the held byte against the frame position
  always_comb begin
    byte_position_next   = byte_position;
    declared_length_next = declared_length;
    running_sum_next     = running_sum;
    sum_high_byte_next   = sum_high_byte;
    held_type_next       = held_type;
    held_counter_next    = held_counter;
    skip_pending_next    = skip_pending;
    kept_count_next      = kept_count;
    restart              = 1'b0;
    has_result           = 1'b0;
    result               = '0;

    if (byte_position < POS_W'(4)) begin
      // start marker hunt
      if (s1_byte != (MARKER_FIRST + {6'd0, byte_position[1:0]})) begin
        restart = 1'b1;
        if (byte_position != '0) begin
          has_result         = 1'b1;
          result.kind        = KIND_DROP;
          result.drop_reason = DROP_MARKER;
        end
      end else begin
        if (byte_position != '0) running_sum_next = sum_plus;
        byte_position_next = byte_position + POS_W'(1);
      end
    end else if (byte_position == POS_W'(4)) begin
      // type byte
      held_type_next   = s1_byte;
      running_sum_next = sum_plus;
      if (s1_byte < cfg.lowest_type || s1_byte > cfg.highest_type) begin
        restart            = 1'b1;
        has_result         = 1'b1;
        result.kind        = KIND_DROP;
        result.frame_type  = s1_byte;
        result.is_ack      = s1_byte[0];
        result.drop_reason = DROP_TYPE;
      end else begin
        byte_position_next = POS_W'(5);
      end
    end else if (byte_position == POS_W'(5)) begin
      // counter byte; acks must carry the expected counter
      held_counter_next = s1_byte;
      running_sum_next  = sum_plus;
      if (held_type[0] && s1_byte != cfg.expected_ack_counter) begin
        restart              = 1'b1;
        has_result           = 1'b1;
        result.kind          = KIND_DROP;
        result.frame_type    = held_type;
        result.frame_counter = s1_byte;
        result.is_ack        = 1'b1;
        result.drop_reason   = DROP_ACK_CNT;
      end else begin
        byte_position_next = POS_W'(6);
      end
    end else if (byte_position == POS_W'(6)) begin
      // encoded length byte
      if ({1'b0, s1_byte} > 9'(MAX_PAYLOAD_LEN)) begin
        restart              = 1'b1;
        has_result           = 1'b1;
        result.kind          = KIND_DROP;
        result.frame_type    = held_type;
        result.frame_counter = held_counter;
        result.is_ack        = held_type[0];
        result.drop_reason   = DROP_LENGTH;
      end else begin
        declared_length_next = LEN_W'(s1_byte);
        running_sum_next     = sum_plus;
        kept_count_next      = '0;
        skip_pending_next    = 1'b0;
        byte_position_next   = POS_W'(7);
      end
    end else if (byte_position < pay_end) begin
      // payload with destuffing
      running_sum_next   = sum_plus;
      byte_position_next = byte_position + POS_W'(1);
      if (skip_pending) begin
        skip_pending_next = 1'b0;
      end else begin
        kept_count_next      = kept_count + LEN_W'(1);
        skip_pending_next    = is_marker;
        has_result           = 1'b1;
        result.kind          = KIND_DATA;
        result.data_byte     = s1_byte;
        result.frame_type    = held_type;
        result.frame_counter = held_counter;
        result.is_ack        = held_type[0];
      end
    end else if (byte_position == pay_end) begin
      // checksum high byte
      sum_high_byte_next = s1_byte;
      byte_position_next = byte_position + POS_W'(1);
    end else if (byte_position == pay_end + POS_W'(1)) begin
      // checksum low byte and final report
      restart              = 1'b1;
      has_result           = 1'b1;
      result.frame_type    = held_type;
      result.frame_counter = held_counter;
      result.is_ack        = held_type[0];
      if ({sum_high_byte, s1_byte} == running_sum) begin
        result.kind           = KIND_ACCEPT;
        result.decoded_length = 7'(kept_count);
      end else begin
        result.kind        = KIND_DROP;
        result.drop_reason = DROP_CHECKSUM;
      end
    end else begin
      restart = 1'b1;
    end

    if (restart) begin
      byte_position_next   = '0;
      declared_length_next = '0;
      running_sum_next     = '0;
      sum_high_byte_next   = '0;
      held_type_next       = '0;
      held_counter_next    = '0;
      skip_pending_next    = 1'b0;
      kept_count_next      = '0;
    end
  end

  // State update once per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      declared_length <= '0;
      running_sum     <= '0;
      sum_high_byte   <= '0;
      held_type       <= '0;
      held_counter    <= '0;
      skip_pending    <= 1'b0;
      kept_count      <= '0;
    end else if (advance) begin
      byte_position   <= byte_position_next;
      declared_length <= declared_length_next;
      running_sum     <= running_sum_next;
      sum_high_byte   <= sum_high_byte_next;
      held_type       <= held_type_next;
      held_counter    <= held_counter_next;
      skip_pending    <= skip_pending_next;
      kept_count      <= kept_count_next;
    end
  end

  assign res_push = advance && has_result;
  assign res_data = result;

endmodule

// ===== hdl/sfd_outbuf.sv =====
// Two-entry result buffer (output register plus skid entry) so that the core
// keeps running while the receiver stalls. Depends on sfd_pkg.
module sfd_outbuf import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  sfd_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_ready,
  output sfd_result_t out_data
);

  logic        skid_valid;
  sfd_result_t skid_data;
  logic        pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  // Control: push never arrives while the skid entry is occupied
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !pop) begin
      if (push) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= push;
    end else begin
      out_valid <= push;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_valid && !pop) begin
      if (push) skid_data <= push_data;
    end else if (skid_valid) begin
      out_data <= skid_data;
      if (push) skid_data <= push_data;
    end else if (push) begin
      out_data <= push_data;
    end
  end

endmodule

// ===== hdl/serial_frame_deframer_unit.sv =====
// Serial frame deframer, top level: configuration port, core and result buffer.
// Depends on sfd_pkg, sfd_if, sfd_regs, sfd_core, sfd_outbuf.
//
// Usage:
//   rx  : one received byte per transaction (valid/ready).
//   res : at most one result per byte: a destuffed payload byte, a frame
//         accept (with decoded length) or a frame drop (with reason).
//   APB : lowest_type at 0x0, highest_type at 0x4, expected_ack_counter at 0x8;
//         write only while no byte is in flight. pready is always high.
// Each result passes the input register and then the output register before it
//   is presented on res.
// Throughput: one byte per cycle while the result buffer has room; every byte
//   is decoded in a single pass through the position compare, the 16-bit sum
//   add and the counter step.
// Reset (rst, synchronous): registers return to 0 / 255 / 0 and the parser
//   hunts for the first marker byte; buffered results are discarded.
// Receiver stall: a two-entry result buffer absorbs one more result; rx.ready
//   falls once both entries are full and a byte waits in the input register,
//   so nothing is lost or repeated.
module serial_frame_deframer_unit import sfd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  sfd_byte_if.sink          rx,
  sfd_result_if.source      res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  sfd_cfg_t    cfg;
  logic        buf_full;
  logic        res_push;
  sfd_result_t res_data;
  sfd_result_t out_data;

  // Configuration registers
  sfd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Frame parser
  sfd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (rx.valid),
    .in_byte  (rx.rx_byte),
    .in_ready (rx.ready),
    .res_full (buf_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  // Result buffer
  sfd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_data)
  );

  assign res.kind           = out_data.kind;
  assign res.data_byte      = out_data.data_byte;
  assign res.frame_type     = out_data.frame_type;
  assign res.frame_counter  = out_data.frame_counter;
  assign res.is_ack         = out_data.is_ack;
  assign res.decoded_length = out_data.decoded_length;
  assign res.drop_reason    = out_data.drop_reason;

  // Input stalls only while a result is waiting at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !rx.ready |-> res.valid)
    else $error("input stalled with no result pending");

  // A result is never pushed into a full buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    buf_full |-> !res_push)
    else $error("result pushed while buffer full");

  // Payload results carry no length or reason
  a_data_fields: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_DATA) |->
      (res.decoded_length == 7'd0 && res.drop_reason == DROP_MARKER))
    else $error("payload result with length or reason set");

  // Accepted length never exceeds the payload limit
  a_accept_len: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind == KIND_ACCEPT) |->
      ({1'b0, res.decoded_length} <= 8'(MAX_PAYLOAD_LEN)))
    else $error("accepted frame longer than the limit");

endmodule
